// File: sv/dcrc_pkg.sv
// ----------------------------------------------------------------------------
// dcrc_pkg
// Shared types, constants and byte-wide CRC-16 helpers for the dual check.
// ----------------------------------------------------------------------------
`default_nettype none

package dcrc_pkg;

    localparam logic [15:0] CRC_POLY = 16'h8005;
    localparam logic [15:0] CRC_INIT = 16'h0000;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        last_byte;
        logic [15:0] reference_crc;
    } t_in_beat;

    typedef struct packed {
        logic        crc_hit;
        logic [15:0] crc_direct;
        logic [15:0] crc_reflected;
    } t_out_beat;

    typedef struct packed {
        logic     valid;
        t_in_beat beat;
    } t_stage;

    function automatic logic [7:0] flip8(input logic [7:0] v);
        logic [7:0] r;
        for (int k = 0; k < 8; k++) begin
            r[7-k] = v[k];
        end
        return r;
    endfunction

    function automatic logic [15:0] flip16(input logic [15:0] v);
        logic [15:0] r;
        for (int k = 0; k < 16; k++) begin
            r[15-k] = v[k];
        end
        return r;
    endfunction

    // absorb one byte MSB first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc;
        for (int k = 7; k >= 0; k--) begin
            if (b[k] ^ c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// File: sv/dcrc_if.sv
// ----------------------------------------------------------------------------
// dcrc_in_if / dcrc_out_if
// Valid/ready channels for byte beats and check results.
// ----------------------------------------------------------------------------
`default_nettype none

interface dcrc_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [15:0] reference_crc;

    modport source (output valid, output data_byte, output last_byte,
                    output reference_crc, input ready);
    modport sink   (input valid, input data_byte, input last_byte,
                    input reference_crc, output ready);
endinterface

interface dcrc_out_if;
    logic        valid;
    logic        ready;
    logic        crc_hit;
    logic [15:0] crc_direct;
    logic [15:0] crc_reflected;

    modport source (output valid, output crc_hit, output crc_direct,
                    output crc_reflected, input ready);
    modport sink   (input valid, input crc_hit, input crc_direct,
                    input crc_reflected, output ready);
endinterface

`default_nettype wire

// File: sv/dcrc_in_stage.sv
// ----------------------------------------------------------------------------
// dcrc_in_stage
// Input register: captures one byte beat and holds it until the core takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module dcrc_in_stage (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    dcrc_in_if.sink              i_byte_ch,
    input  wire logic            i_advance,
    output dcrc_pkg::t_stage     o_stage
);

    logic             r_valid;
    dcrc_pkg::t_in_beat r_beat;
    logic             w_take;

    assign i_byte_ch.ready = !r_valid || i_advance;
    assign w_take          = i_byte_ch.valid && i_byte_ch.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_beat.data_byte     <= i_byte_ch.data_byte;
            r_beat.last_byte     <= i_byte_ch.last_byte;
            r_beat.reference_crc <= i_byte_ch.reference_crc;
        end
    end

    assign o_stage.valid = r_valid;
    assign o_stage.beat  = r_beat;

endmodule

`default_nettype wire

// File: sv/dcrc_core.sv
// ----------------------------------------------------------------------------
// dcrc_core
// Running CRC registers, final compare and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module dcrc_core (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire dcrc_pkg::t_stage  i_stage,
    output logic                   o_advance,
    dcrc_out_if.source             o_result_ch
);

    logic [15:0]          r_direct;
    logic [15:0]          r_reflected;
    logic [15:0]          n_direct;
    logic [15:0]          n_reflected;
    logic                 r_out_valid;
    dcrc_pkg::t_out_beat  r_out;
    logic [15:0]          w_refl_final;
    logic                 w_last_adv;

    assign o_advance = i_stage.valid &&
                       (!i_stage.beat.last_byte || !r_out_valid || o_result_ch.ready);
    assign w_last_adv = o_advance && i_stage.beat.last_byte;

    assign n_direct     = dcrc_pkg::crc_byte(r_direct, i_stage.beat.data_byte);
    assign n_reflected  = dcrc_pkg::crc_byte(r_reflected,
                                             dcrc_pkg::flip8(i_stage.beat.data_byte));
    assign w_refl_final = dcrc_pkg::flip16(n_reflected);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direct    <= dcrc_pkg::CRC_INIT;
            r_reflected <= dcrc_pkg::CRC_INIT;
        end else if (w_last_adv) begin
            r_direct    <= dcrc_pkg::CRC_INIT;
            r_reflected <= dcrc_pkg::CRC_INIT;
        end else if (o_advance) begin
            r_direct    <= n_direct;
            r_reflected <= n_reflected;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_last_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_result_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_last_adv) begin
            r_out.crc_hit       <= (n_direct == i_stage.beat.reference_crc) ||
                                   (w_refl_final == i_stage.beat.reference_crc);
            r_out.crc_direct    <= n_direct;
            r_out.crc_reflected <= w_refl_final;
        end
    end

    assign o_result_ch.valid         = r_out_valid;
    assign o_result_ch.crc_hit       = r_out.crc_hit;
    assign o_result_ch.crc_direct    = r_out.crc_direct;
    assign o_result_ch.crc_reflected = r_out.crc_reflected;

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_last_adv |=> (r_direct == dcrc_pkg::CRC_INIT) &&
                       (r_reflected == dcrc_pkg::CRC_INIT))
        else $error("crc registers not cleared after last beat");

    a_rose_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_last_adv))
        else $error("result appeared without a last beat");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_advance |=> $stable(r_direct) && $stable(r_reflected))
        else $error("crc registers moved without a beat");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_result_ch.ready) |-> !w_last_adv)
        else $error("pending result overwritten");

endmodule

`default_nettype wire

// File: sv/dual_crc16_check_unit.sv
// ----------------------------------------------------------------------------
// dual_crc16_check_unit
// Checks a byte block against a reference CRC with CRC-16/BUYPASS and ARC.
// ----------------------------------------------------------------------------
// Accepts one byte per clock cycle while nothing stalls. Each byte is absorbed into
// both CRC-16 registers (poly 0x8005, init 0) by one byte-wide XOR update
// between the input register and the CRC registers. On the last byte of a
// block the result beat appears in the cycle after the core takes it, and both
// CRCs restart from zero; the input keeps flowing while a result waits, and only
// a last byte stalls when an earlier result has not been taken.
`default_nettype none

module dual_crc16_check_unit (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    dcrc_in_if.sink     i_byte_ch,
    dcrc_out_if.source  o_result_ch
);

    dcrc_pkg::t_stage w_stage;
    logic             w_advance;

    dcrc_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_byte_ch (i_byte_ch),
        .i_advance (w_advance),
        .o_stage   (w_stage)
    );

    dcrc_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_stage     (w_stage),
        .o_advance   (w_advance),
        .o_result_ch (o_result_ch)
    );

endmodule

`default_nettype wire

// File: verif/dual_crc16_check_checker.sv
// ----------------------------------------------------------------------------
// dual_crc16_check_checker
// Watches both channels of the dual CRC-16 check unit, predicts every result
// beat from the accepted byte beats and compares it field by field.
// ----------------------------------------------------------------------------
module dual_crc16_check_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    dcrc_in_if   byte_ch,
    dcrc_out_if  result_ch,
    output int   o_fail_count,
    output int   o_pending
);

    timeunit 1ns;
    timeprecision 1ps;

    logic [15:0]         direct_crc;
    logic [15:0]         mirrored_crc;
    dcrc_pkg::t_out_beat awaited_results[$];

    function automatic logic [15:0] crc16_absorb(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] r;
        logic        fb;
        r = crc;
        for (int k = 7; k >= 0; k--) begin
            fb = r[15] ^ b[k];
            r  = {r[14:0], 1'b0};
            if (fb) begin
                r = r ^ dcrc_pkg::CRC_POLY;
            end
        end
        return r;
    endfunction

    task automatic note_failure(input string msg);
        o_fail_count++;
        if (o_fail_count <= 10) begin
            $display("%0t mismatch: %s", $realtime, msg);
        end
    endtask

    always @(posedge i_clk) begin
        dcrc_pkg::t_out_beat want;
        dcrc_pkg::t_out_beat got;
        logic [7:0]          mirrored_byte;
        logic [15:0]         unmirrored;
        if (!i_rst_n) begin
            direct_crc   = dcrc_pkg::CRC_INIT;
            mirrored_crc = dcrc_pkg::CRC_INIT;
            awaited_results.delete();
            o_fail_count = 0;
        end else begin
            if (result_ch.valid && result_ch.ready) begin
                got.crc_hit       = result_ch.crc_hit;
                got.crc_direct    = result_ch.crc_direct;
                got.crc_reflected = result_ch.crc_reflected;
                if (awaited_results.size() == 0) begin
                    note_failure($sformatf("result %b/%h/%h with nothing awaited",
                                           got.crc_hit, got.crc_direct, got.crc_reflected));
                end else begin
                    want = awaited_results.pop_front();
                    if (got.crc_hit !== want.crc_hit) begin
                        note_failure($sformatf("crc_hit expected %b got %b",
                                               want.crc_hit, got.crc_hit));
                    end
                    if (got.crc_direct !== want.crc_direct) begin
                        note_failure($sformatf("crc_direct expected %h got %h",
                                               want.crc_direct, got.crc_direct));
                    end
                    if (got.crc_reflected !== want.crc_reflected) begin
                        note_failure($sformatf("crc_reflected expected %h got %h",
                                               want.crc_reflected, got.crc_reflected));
                    end
                end
            end
            if (byte_ch.valid && byte_ch.ready) begin
                mirrored_byte = {<<{byte_ch.data_byte}};
                direct_crc    = crc16_absorb(direct_crc, byte_ch.data_byte);
                mirrored_crc  = crc16_absorb(mirrored_crc, mirrored_byte);
                if (byte_ch.last_byte) begin
                    unmirrored         = {<<{mirrored_crc}};
                    want.crc_direct    = direct_crc;
                    want.crc_reflected = unmirrored;
                    want.crc_hit       = (direct_crc == byte_ch.reference_crc) ||
                                         (unmirrored == byte_ch.reference_crc);
                    awaited_results.push_back(want);
                    direct_crc   = dcrc_pkg::CRC_INIT;
                    mirrored_crc = dcrc_pkg::CRC_INIT;
                end
            end
        end
        o_pending = awaited_results.size();
    end

endmodule

// File: verif/dual_crc16_check_unit_tb.sv
// ----------------------------------------------------------------------------
// dual_crc16_check_unit_tb
// Feeds byte blocks with matching and random reference CRCs into the dual
// CRC-16 check unit under random idling, a long result hold-off and a full
// drain, and reports the verdict of the checker.
// ----------------------------------------------------------------------------
module dual_crc16_check_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_BEATS = 1150;
    localparam int HOLD_CYCLES  = 400;
    localparam int TAIL_CYCLES  = 8;
    localparam int CYCLE_LIMIT  = 200000;

    typedef enum int {REF_DIRECT, REF_REFLECTED, REF_GIVEN} t_ref_choice;

    logic i_clk;
    logic i_rst_n;
    logic steady_stream;
    int   hold_requests;
    int   fail_count;
    int   pending;
    int   beats_sent;
    int   cycle_count;

    dcrc_in_if  byte_ch ();
    dcrc_out_if result_ch ();

    dual_crc16_check_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_byte_ch   (byte_ch),
        .o_result_ch (result_ch)
    );

    dual_crc16_check_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .byte_ch      (byte_ch),
        .result_ch    (result_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #1 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // result side: random idling, long hold-off on request
    initial begin
        int holds_served;
        holds_served = 0;
        result_ch.ready <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (holds_served != hold_requests) begin
                holds_served = hold_requests;
                result_ch.ready <= 1'b0;
                for (int n = 0; n < HOLD_CYCLES; n++) begin
                    @(posedge i_clk);
                end
            end else begin
                result_ch.ready <= steady_stream || ($urandom_range(0, 99) >= 7);
                @(posedge i_clk);
            end
        end
    end

    task automatic send_beat(input logic [7:0] data, input logic last, input logic [15:0] ref_crc);
        while (!steady_stream && $urandom_range(0, 99) < 7) begin
            byte_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        byte_ch.valid         <= 1'b1;
        byte_ch.data_byte     <= data;
        byte_ch.last_byte     <= last;
        byte_ch.reference_crc <= ref_crc;
        do begin
            @(posedge i_clk);
        end while (!byte_ch.ready);
        beats_sent++;
    endtask

    task automatic send_block(input logic [7:0] blk[$], input t_ref_choice choice,
                              input logic [15:0] given_ref);
        logic [15:0] run_direct;
        logic [15:0] run_mirrored;
        logic [15:0] final_ref;
        logic [7:0]  mirrored_byte;
        run_direct   = dcrc_pkg::CRC_INIT;
        run_mirrored = dcrc_pkg::CRC_INIT;
        foreach (blk[i]) begin
            mirrored_byte = {<<{blk[i]}};
            run_direct    = chk.crc16_absorb(run_direct, blk[i]);
            run_mirrored  = chk.crc16_absorb(run_mirrored, mirrored_byte);
        end
        case (choice)
            REF_DIRECT: begin
                final_ref = run_direct;
            end
            REF_REFLECTED: begin
                final_ref = {<<{run_mirrored}};
            end
            default: begin
                final_ref = given_ref;
            end
        endcase
        foreach (blk[i]) begin
            if (i == blk.size() - 1) begin
                send_beat(blk[i], 1'b1, final_ref);
            end else begin
                send_beat(blk[i], 1'b0, 16'($urandom()));
            end
        end
    endtask

    task automatic send_random_block(input int max_len);
        logic [7:0]  blk[$];
        int          len;
        int          pick;
        t_ref_choice choice;
        len = $urandom_range(1, max_len);
        for (int i = 0; i < len; i++) begin
            blk.push_back(8'($urandom()));
        end
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            choice = REF_DIRECT;
        end else if (pick < 70) begin
            choice = REF_REFLECTED;
        end else begin
            choice = REF_GIVEN;
        end
        send_block(blk, choice, 16'($urandom()));
    endtask

    task automatic drain_results();
        byte_ch.valid <= 1'b0;
        do begin
            @(negedge i_clk);
        end while (pending != 0);
        @(posedge i_clk);
    endtask

    initial begin
        bit hold_done;
        bit drain_done;
        hold_done  = 1'b0;
        drain_done = 1'b0;
        beats_sent = 0;
        i_rst_n               <= 1'b0;
        steady_stream         <= 1'b0;
        hold_requests         <= 0;
        byte_ch.valid         <= 1'b0;
        byte_ch.data_byte     <= 8'h00;
        byte_ch.last_byte     <= 1'b0;
        byte_ch.reference_crc <= 16'h0000;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_block('{8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39},
                   REF_GIVEN, 16'hFEE8);
        send_block('{8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39},
                   REF_GIVEN, 16'hBB3D);
        send_block('{8'h00}, REF_GIVEN, 16'h0000);
        send_block('{8'hFF}, REF_GIVEN, 16'hFFFF);
        send_block('{8'hA5, 8'h5A}, REF_GIVEN, 16'h1234);

        beats_sent = 0;
        while (beats_sent < RANDOM_BEATS) begin
            steady_stream <= (beats_sent >= 300 && beats_sent < 550);
            if (!hold_done && beats_sent >= 650) begin
                hold_done = 1'b1;
                hold_requests <= hold_requests + 1;
                for (int b = 0; b < 25; b++) begin
                    send_random_block(2);
                end
            end else if (!drain_done && beats_sent >= 850) begin
                drain_done = 1'b1;
                drain_results();
            end else if ($urandom_range(0, 9) == 0) begin
                send_random_block(40);
            end else begin
                send_random_block(8);
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// File: files.f
sv/dcrc_pkg.sv
sv/dcrc_if.sv
sv/dcrc_in_stage.sv
sv/dcrc_core.sv
sv/dual_crc16_check_unit.sv
verif/dual_crc16_check_checker.sv
verif/dual_crc16_check_unit_tb.sv
